// File: hw/rtl/cbed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbed_pkg
// shared types and constants for the channel busy energy detector
// ----------------------------------------------------------------------------
package cbed_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;

    localparam logic KIND_OBSERVE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [15:0] THRESHOLD_RESET = 16'd1638;
    localparam logic [15:0] HOLD_RESET = 16'd200;
    localparam logic [15:0] WINDOW_RESET = 16'd100;

    typedef struct packed {
        logic        kind;
        logic [31:0] now_ms;
        logic [15:0] level;
        logic        blackout;
        logic [15:0] guard_ms;
    } req_t;

    typedef struct packed {
        logic        idle;
        logic [15:0] window_mean;
        logic [15:0] current_level;
        logic [31:0] quiet_ms;
        logic [31:0] last_busy_ms;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DROP_RD,
        ST_DROP_WAIT,
        ST_DROP_DO,
        ST_APPEND,
        ST_PRUNE_RD,
        ST_PRUNE_WAIT,
        ST_PRUNE_CHK,
        ST_DIV,
        ST_DECIDE,
        ST_OUT
    } state_t;

endpackage

// File: hw/rtl/cbed_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbed_req_if / cbed_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface cbed_req_if;
    logic           valid;
    logic           ready;
    cbed_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cbed_rsp_if;
    logic           valid;
    logic           ready;
    cbed_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/cbed_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbed_ram
// generic simple dual-port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module cbed_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/cbed_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbed_front
// accepts requests into a two-entry queue toward the window engine
// ----------------------------------------------------------------------------
module cbed_front (
    input  logic clk,
    input  logic rst_n,
    cbed_req_if.sink   in,
    cbed_req_if.source q
);
    cbed_pkg::req_t slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push, pop;

    assign in.ready = (cnt_reg != 2'd2);
    assign push = in.valid && in.ready;
    assign pop = q.valid && q.ready;
    assign q.valid = (cnt_reg != 2'd0);
    assign q.data = slot_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= in.data;
        end
    end
endmodule

// File: hw/rtl/cbed_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbed_back
// window engine: append, prune, serial mean divide and quiet tracking
// ----------------------------------------------------------------------------
module cbed_back #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [15:0]                      threshold,
    input  logic [15:0]                      hold,
    input  logic [15:0]                      window,
    cbed_req_if.sink                         q,
    cbed_rsp_if.source                       out
);
    localparam int IW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = CW + 16;
    localparam int DIV_CNT_W = $clog2(SW + 1);

    cbed_pkg::state_t state_reg, state_next;
    cbed_pkg::req_t   req_reg;
    cbed_pkg::rsp_t   rsp_reg;

    logic [IW-1:0] oldest_reg;
    logic [CW-1:0] count_reg;
    logic [SW-1:0] sum_reg;
    logic [15:0]   last_level_reg;
    logic          quiet_run_reg, quiet_rst_reg;
    logic [31:0]   quiet_start_reg, busy_reg;
    logic          out_valid_reg;

    // divider
    logic [SW-1:0]        quo_reg;
    logic [CW:0]          rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [IW-1:0] raddr, waddr, slot;
    logic [CW:0]   slot_sum;
    logic [IW-1:0] oldest_inc;
    logic          we;
    logic [31:0]   t_rd;
    logic [15:0]   l_rd;
    logic [31:0]   age;
    logic [31:0]   win;
    logic [CW:0]   rem_sh;
    logic [15:0]   mean;
    logic [31:0]   quiet;
    logic [32:0]   need;

    cbed_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_time (
        .clk(clk), .we(we), .waddr(waddr), .wdata(req_reg.now_ms),
        .raddr(raddr), .rdata(t_rd)
    );
    cbed_ram #(.WIDTH(16), .DEPTH(WINDOW_DEPTH)) u_level (
        .clk(clk), .we(we), .waddr(waddr), .wdata(req_reg.level),
        .raddr(raddr), .rdata(l_rd)
    );

    // circular index wrap by compare
    assign slot_sum = (CW+1)'(oldest_reg) + {1'b0, count_reg};
    assign slot = (slot_sum >= (CW+1)'(WINDOW_DEPTH))
        ? IW'(slot_sum - (CW+1)'(WINDOW_DEPTH)) : IW'(slot_sum);
    assign oldest_inc = (oldest_reg == IW'(WINDOW_DEPTH - 1)) ? '0 : oldest_reg + IW'(1);
    assign waddr = slot;
    assign we = (state_reg == cbed_pkg::ST_APPEND);
    assign raddr = oldest_reg;
    assign age = req_reg.now_ms - t_rd;
    assign win = (window == 16'd0) ? 32'd1 : {16'd0, window};
    assign rem_sh = {rem_reg[CW-1:0], quo_reg[SW-1]};
    assign mean = (count_reg == '0) ? 16'd0 : quo_reg[15:0];

    assign q.ready = (state_reg == cbed_pkg::ST_IDLE);
    assign out.valid = out_valid_reg;
    assign out.data = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cbed_pkg::ST_IDLE:
                if (q.valid)
                begin
                    state_next = cbed_pkg::ST_DIV;
                    if (q.data.kind == cbed_pkg::KIND_OBSERVE && !q.data.blackout)
                    begin
                        state_next = (count_reg >= CW'(WINDOW_DEPTH))
                            ? cbed_pkg::ST_DROP_RD : cbed_pkg::ST_APPEND;
                    end
                end
            cbed_pkg::ST_DROP_RD:    state_next = cbed_pkg::ST_DROP_WAIT;
            cbed_pkg::ST_DROP_WAIT:  state_next = cbed_pkg::ST_DROP_DO;
            cbed_pkg::ST_DROP_DO:    state_next = cbed_pkg::ST_APPEND;
            cbed_pkg::ST_APPEND:     state_next = cbed_pkg::ST_PRUNE_RD;
            cbed_pkg::ST_PRUNE_RD:   state_next = cbed_pkg::ST_PRUNE_WAIT;
            cbed_pkg::ST_PRUNE_WAIT: state_next = cbed_pkg::ST_PRUNE_CHK;
            cbed_pkg::ST_PRUNE_CHK:
                if (count_reg != '0 && age > win)
                begin
                    state_next = cbed_pkg::ST_PRUNE_RD;
                end
                else
                begin
                    state_next = cbed_pkg::ST_DIV;
                end
            cbed_pkg::ST_DIV:
                if (div_cnt_reg == DIV_CNT_W'(SW))
                begin
                    state_next = cbed_pkg::ST_DECIDE;
                end
            cbed_pkg::ST_DECIDE:     state_next = cbed_pkg::ST_OUT;
            cbed_pkg::ST_OUT:
                if (!out_valid_reg)
                begin
                    state_next = cbed_pkg::ST_IDLE;
                end
            default:                 state_next = cbed_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (!quiet_run_reg)
        begin
            quiet = 32'd0;
        end
        else if (quiet_rst_reg)
        begin
            quiet = 32'hFFFF_FFFF;
        end
        else
        begin
            quiet = req_reg.now_ms - quiet_start_reg;
        end
        need = {17'd0, hold} + {17'd0, req_reg.guard_ms};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbed_pkg::ST_IDLE;
            oldest_reg <= '0;
            count_reg <= '0;
            sum_reg <= '0;
            last_level_reg <= 16'd0;
            quiet_run_reg <= 1'b1;
            quiet_rst_reg <= 1'b1;
            quiet_start_reg <= 32'd0;
            busy_reg <= 32'd0;
            out_valid_reg <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                cbed_pkg::ST_IDLE:
                    if (q.valid && q.data.kind == cbed_pkg::KIND_OBSERVE)
                    begin
                        last_level_reg <= q.data.level;
                        if (q.data.blackout)
                        begin
                            count_reg <= '0;
                            sum_reg <= '0;
                            busy_reg <= q.data.now_ms;
                            quiet_run_reg <= 1'b0;
                            quiet_rst_reg <= 1'b0;
                        end
                    end
                cbed_pkg::ST_DROP_DO:
                begin
                    sum_reg <= sum_reg - SW'(l_rd);
                    oldest_reg <= oldest_inc;
                    count_reg <= count_reg - CW'(1);
                end
                cbed_pkg::ST_APPEND:
                begin
                    count_reg <= count_reg + CW'(1);
                    sum_reg <= sum_reg + SW'(req_reg.level);
                end
                cbed_pkg::ST_PRUNE_CHK:
                    if (count_reg != '0 && age > win)
                    begin
                        sum_reg <= (count_reg == CW'(1)) ? '0 : sum_reg - SW'(l_rd);
                        oldest_reg <= oldest_inc;
                        count_reg <= count_reg - CW'(1);
                    end
                cbed_pkg::ST_DIV:
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                cbed_pkg::ST_DECIDE:
                begin
                    div_cnt_reg <= '0;
                    if (req_reg.kind == cbed_pkg::KIND_OBSERVE && !req_reg.blackout)
                    begin
                        if (mean > threshold)
                        begin
                            busy_reg <= req_reg.now_ms;
                            quiet_run_reg <= 1'b0;
                            quiet_rst_reg <= 1'b0;
                        end
                        else if (!quiet_run_reg)
                        begin
                            quiet_run_reg <= 1'b1;
                            quiet_rst_reg <= 1'b0;
                            quiet_start_reg <= req_reg.now_ms;
                        end
                    end
                end
                cbed_pkg::ST_OUT:
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == cbed_pkg::ST_IDLE && q.valid)
        begin
            req_reg <= q.data;
        end
        if (state_reg == cbed_pkg::ST_DIV)
        begin
            if (div_cnt_reg == '0)
            begin
                quo_reg <= sum_reg;
                rem_reg <= '0;
            end
            else
            begin
                // restoring divide step, one quotient bit
                if (rem_sh >= {1'b0, count_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, count_reg};
                    quo_reg <= {quo_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[SW-2:0], 1'b0};
                end
            end
        end
        if (state_reg == cbed_pkg::ST_OUT && !out_valid_reg)
        begin
            rsp_reg.idle <= quiet_run_reg && ({1'b0, quiet} >= need);
            rsp_reg.window_mean <= mean;
            rsp_reg.current_level <= last_level_reg;
            rsp_reg.quiet_ms <= quiet;
            rsp_reg.last_busy_ms <= busy_reg;
        end
    end
endmodule

// File: hw/rtl/channel_busy_energy_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_busy_energy_detector
// energy-detect carrier sense over a time-stamped level window
// ----------------------------------------------------------------------------
// flow: an observe drops the oldest entry when the store is full, appends, then
//   prunes expired entries one ram read at a time; queries and blackouts go straight
//   to a serial mean divide over clog2(depth+1)+16 bits, which every request runs
// throughput: one request at a time in the window engine; two queued in front
// reset: empty window, idle with quiet time saturated, registers at defaults
module channel_busy_energy_detector #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic                               cfg_we,
    input  logic [cbed_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cbed_pkg::CFG_DATA_W-1:0]    cfg_data,
    cbed_req_if.sink                           in,
    cbed_rsp_if.source                         out
);
    logic [15:0] threshold_reg, hold_reg, window_reg;

    cbed_req_if q_if ();

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= cbed_pkg::THRESHOLD_RESET;
            hold_reg <= cbed_pkg::HOLD_RESET;
            window_reg <= cbed_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cbed_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data;
                cbed_pkg::CFG_HOLD:      hold_reg <= cfg_data;
                cbed_pkg::CFG_WINDOW:    window_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    cbed_front u_front (
        .clk(clk), .rst_n(rst_n), .in(in), .q(q_if.source)
    );

    cbed_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .threshold(threshold_reg), .hold(hold_reg), .window(window_reg),
        .q(q_if.sink), .out(out)
    );
endmodule
